### rtl/core/cfd_pkg.sv
// shared types, constants and register codes for the cppm frame decoder
package cfd_pkg;

  localparam int NumChannels = 8;
  localparam int DataBits    = 16;
  localparam int TimeBits    = 32;
  localparam int IdleBits    = 4;
  localparam int IndexBits   = $clog2(NumChannels);
  localparam int RawDepth    = NumChannels - 1;
  localparam int InBytes     = (TimeBits + 7) / 8;
  localparam int InDataBits  = InBytes * 8;
  localparam int OutBytes    = (NumChannels * DataBits + TimeBits + 7) / 8;
  localparam int OutDataBits = OutBytes * 8;

  localparam logic [DataBits-1:0]  GapMax    = '1;
  localparam logic [DataBits-1:0]  SwitchTop = DataBits'(2000);
  localparam logic [TimeBits-1:0]  PrevEdgeReset = TimeBits'(65535);
  localparam logic [IndexBits-1:0] LastChan  = IndexBits'(NumChannels - 1);

  localparam logic [DataBits-1:0] SyncGapReset     = DataBits'(3000);
  localparam logic [DataBits-1:0] CenterLowReset   = DataBits'(1476);
  localparam logic [DataBits-1:0] CenterHighReset  = DataBits'(1524);
  localparam logic [DataBits-1:0] CenterValueReset = DataBits'(1500);
  localparam logic [DataBits-1:0] FloorValueReset  = DataBits'(1000);
  localparam logic [DataBits-1:0] SwitchHighReset  = DataBits'(1600);
  localparam logic [DataBits-1:0] SwitchLowReset   = DataBits'(1200);
  localparam logic [IdleBits-1:0] IdleCountReset   = IdleBits'(10);

  typedef enum logic [2:0] {
    REG_SYNC_GAP     = 3'd0,
    REG_CENTER_LOW   = 3'd1,
    REG_CENTER_HIGH  = 3'd2,
    REG_CENTER_VALUE = 3'd3,
    REG_FLOOR_VALUE  = 3'd4,
    REG_SWITCH_HIGH  = 3'd5,
    REG_SWITCH_LOW   = 3'd6,
    REG_IDLE_COUNT   = 3'd7
  } cfg_reg_e;

  typedef logic [NumChannels-1:0][DataBits-1:0] chan_vec_t;

  typedef struct packed {
    logic [DataBits-1:0] sync_gap;
    logic [DataBits-1:0] center_low;
    logic [DataBits-1:0] center_high;
    logic [DataBits-1:0] center_value;
    logic [DataBits-1:0] floor_value;
    logic [DataBits-1:0] switch_high;
    logic [DataBits-1:0] switch_low;
    logic [IdleBits-1:0] idle_count;
  } cfg_t;

  typedef struct packed {
    logic [TimeBits-1:0] last_edge;
    chan_vec_t           chan;
    logic                in_sync;
    logic                frame_done;
  } result_t;

endpackage

### rtl/core/cfd_cfg_regs.sv
// configuration register file written through the plain write port
module cfd_cfg_regs
  import cfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [DataBits-1:0] cfg_data,
  output cfg_t                cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_gap     <= SyncGapReset;
      cfg.center_low   <= CenterLowReset;
      cfg.center_high  <= CenterHighReset;
      cfg.center_value <= CenterValueReset;
      cfg.floor_value  <= FloorValueReset;
      cfg.switch_high  <= SwitchHighReset;
      cfg.switch_low   <= SwitchLowReset;
      cfg.idle_count   <= IdleCountReset;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_SYNC_GAP:     cfg.sync_gap     <= cfg_data;
        REG_CENTER_LOW:   cfg.center_low   <= cfg_data;
        REG_CENTER_HIGH:  cfg.center_high  <= cfg_data;
        REG_CENTER_VALUE: cfg.center_value <= cfg_data;
        REG_FLOOR_VALUE:  cfg.floor_value  <= cfg_data;
        REG_SWITCH_HIGH:  cfg.switch_high  <= cfg_data;
        REG_SWITCH_LOW:   cfg.switch_low   <= cfg_data;
        REG_IDLE_COUNT:   cfg.idle_count   <= cfg_data[IdleBits-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/core/cfd_condition.sv
// frame conditioning: deadband, floors, three-level switch and idle detect
module cfd_condition
  import cfd_pkg::*;
(
  input  chan_vec_t raw,
  input  cfg_t      cfg,
  output chan_vec_t cond,
  output logic      idle
);

  always_comb begin
    cond = raw;
    for (int i = 0; i < 4; i++) begin
      if (raw[i] <= cfg.center_high && raw[i] >= cfg.center_low) begin
        cond[i] = cfg.center_value;
      end
    end
    if (raw[4] <= cfg.floor_value) begin
      cond[4] = cfg.floor_value;
    end
    if (raw[6] <= cfg.floor_value) begin
      cond[6] = cfg.floor_value;
    end
    if (raw[7] > cfg.switch_high) begin
      cond[7] = SwitchTop;
    end else if (raw[7] < cfg.switch_low) begin
      cond[7] = cfg.floor_value;
    end else begin
      cond[7] = cfg.center_value;
    end
  end

  assign idle = cond[0] == cfg.center_value && cond[1] == cfg.center_value &&
                cond[2] == cfg.center_value && cond[3] == cfg.center_value &&
                cond[4] == cfg.floor_value && cond[6] == cfg.floor_value;

endmodule

### rtl/core/cfd_tracker.sv
// edge gap, sync and channel capture state with published channel values
module cfd_tracker
  import cfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [TimeBits-1:0] edge_time,
  input  cfg_t                cfg,
  output result_t             result
);

  logic [TimeBits-1:0]  prev_edge;
  logic                 synced;
  logic [IndexBits-1:0] chan_index;
  logic [DataBits-1:0]  raw_widths [RawDepth];
  chan_vec_t            published;
  logic [IdleBits-1:0]  idle_frames;

  logic                 synced_next;
  logic [IndexBits-1:0] chan_index_next;
  chan_vec_t            published_next;
  logic [IdleBits-1:0]  idle_frames_next;
  logic [IdleBits-1:0]  idle_bumped;

  logic [TimeBits-1:0]  gap_full;
  logic [DataBits-1:0]  gap;
  logic                 frame_end;
  chan_vec_t            frame_raw;
  chan_vec_t            frame_cond;
  logic                 frame_idle;

  assign gap_full  = edge_time - prev_edge;
  assign gap       = (|gap_full[TimeBits-1:DataBits]) ? GapMax : gap_full[DataBits-1:0];
  assign frame_end = synced && chan_index == LastChan;

  always_comb begin
    for (int i = 0; i < RawDepth; i++) begin
      frame_raw[i] = raw_widths[i];
    end
    frame_raw[NumChannels-1] = gap;
  end

  cfd_condition u_condition (
    .raw  (frame_raw),
    .cfg  (cfg),
    .cond (frame_cond),
    .idle (frame_idle)
  );

  always_comb begin
    synced_next      = synced;
    chan_index_next  = chan_index;
    published_next   = published;
    idle_frames_next = idle_frames;
    idle_bumped      = frame_idle ? idle_frames + 1'b1 : idle_frames;
    if (synced) begin
      if (frame_end) begin
        chan_index_next   = '0;
        synced_next       = 1'b0;
        published_next[5] = frame_cond[5];
        idle_frames_next  = idle_bumped;
        if (!frame_idle || idle_bumped == cfg.idle_count) begin
          for (int i = 0; i < NumChannels; i++) begin
            if (i != 5) begin
              published_next[i] = frame_cond[i];
            end
          end
        end
        if (idle_bumped == cfg.idle_count) begin
          idle_frames_next = '0;
        end
      end else begin
        chan_index_next = chan_index + 1'b1;
      end
    end else begin
      synced_next = gap > cfg.sync_gap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_edge   <= PrevEdgeReset;
      synced      <= 1'b0;
      chan_index  <= '0;
      published   <= '0;
      idle_frames <= '0;
    end else if (step) begin
      prev_edge   <= edge_time;
      synced      <= synced_next;
      chan_index  <= chan_index_next;
      published   <= published_next;
      idle_frames <= idle_frames_next;
    end
  end

  // channel store, written without reset
  always_ff @(posedge clk) begin
    if (step && synced && !frame_end) begin
      raw_widths[chan_index] <= gap;
    end
  end

  assign result.last_edge  = edge_time;
  assign result.chan       = published_next;
  assign result.in_sync    = synced_next;
  assign result.frame_done = frame_end;

endmodule

### rtl/core/cfd_out_stage.sv
// result register toward the master-side stream
module cfd_out_stage
  import cfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_in,
  input  logic    m_tready,
  output logic    m_tvalid,
  output logic    free,
  output result_t result_out
);

  assign free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_out <= result_in;
    end
  end

endmodule

### rtl/core/cppm_frame_decoder_top.sv
// top level of the eight-channel cppm frame decoder
//
//  port group     dir   contents
//  s_t*           in    edge request: s_tdata = edge_time
//  m_t*           out   frame result: tdata = chan0..chan7, last_edge; tlast = frame_done
//  cfg_*          in    register write: cfg_index selects, cfg_data written
//
// one request enters each cycle while the result is not stalled; it passes the input register, then the result register
// the gap subtract, deadband compares and publish select are combinational between the two
// reset is synchronous; configuration registers come back with their default values
// a stalled result holds, and one more request is held in the input register
module cppm_frame_decoder_top
  import cfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [InDataBits-1:0]  s_tdata,   // [31:0] edge_time
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OutDataBits-1:0] m_tdata,   // chan0 .. chan7, 16 bits each, then last_edge
  output logic                   m_tlast,   // frame_done
  output logic                   m_tuser,   // in_sync
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [DataBits-1:0]    cfg_data
);

  cfg_t                cfg;
  logic                in_valid;
  logic [TimeBits-1:0] in_edge;
  logic                out_free;
  logic                step;
  result_t             result;
  result_t             result_q;

  cfd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_edge <= s_tdata[TimeBits-1:0];
    end
  end

  cfd_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .edge_time (in_edge),
    .cfg       (cfg),
    .result    (result)
  );

  cfd_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load       (step),
    .result_in  (result),
    .m_tready   (m_tready),
    .m_tvalid   (m_tvalid),
    .free       (out_free),
    .result_out (result_q)
  );

  assign m_tdata = OutDataBits'({result_q.last_edge, result_q.chan});
  assign m_tlast = result_q.frame_done;
  assign m_tuser = result_q.in_sync;

endmodule

### rtl/core/cfd_checker.sv
// port-level checks for the cppm frame decoder, bound to the top level
module cfd_port_checks
  import cfd_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OutDataBits-1:0] m_tdata,
  input logic                   m_tlast,
  input logic                   m_tuser
);

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a completed frame always drops sync
  a_frame_drops_sync: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser)
    else $error("sync still set on frame completion");

  // requests are refused only while a result is stalled
  a_refuse_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("request refused without an output stall");

  // a stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
      && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind cppm_frame_decoder_top cfd_port_checks u_cfd_checker (.*);
